### src/timed_task_queue_with_cancel_top_macros.svh
// Assertion macros for the timed task queue checker.
// Uses the clock and reset names of the module that includes it.
`ifndef TIMED_TASK_QUEUE_WITH_CANCEL_TOP_MACROS_SVH
`define TIMED_TASK_QUEUE_WITH_CANCEL_TOP_MACROS_SVH

// same-cycle implication
`define TTQ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TTQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/ttq_pkg.sv
// Shared types and constants of the timed task queue.
// No dependencies.
package ttq_pkg;

   localparam int MAX_RESULTS = 16;
   localparam int RES_W       = $clog2(MAX_RESULTS);
   localparam logic [RES_W-1:0] RES_LAST = RES_W'(MAX_RESULTS - 1);

   typedef enum logic [1:0] {
      OP_SCHEDULE = 2'd0,
      OP_CANCEL   = 2'd1,
      OP_TICK     = 2'd2
   } op_type;

   localparam logic [1:0] RK_ASSIGNED = 2'd0;
   localparam logic [1:0] RK_CANCEL   = 2'd1;
   localparam logic [1:0] RK_DUE      = 2'd2;
   localparam logic [1:0] RK_FULL     = 2'd3;

   typedef struct packed {
      op_type      op;
      logic [47:0] time_val;
      logic [31:0] id;
   } cmd_type;

   typedef struct packed {
      logic    vld;
      cmd_type cmd;
   } head_type;

   typedef struct packed {
      logic [31:0] id;
      logic [47:0] due;
   } entry_type;

   typedef struct packed {
      logic        strobe;
      logic [1:0]  kind;
      logic [31:0] task_id;
      logic        found;
      logic        last;
   } rsp_type;

endpackage

### src/ttq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ttq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/ttq_front.sv
// Front end: accepts transactions, decodes the kind, queues commands.
// Depends on ttq_pkg.
module ttq_front
   import ttq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [47:0] req_due_time,
   input  logic [31:0] req_cancel_id,
   input  logic [47:0] req_current_time,
   input  logic        pop,
   output head_type    head
);

   cmd_type    mem_ff [2];
   cmd_type    cmd_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic       accept;

   assign busy   = (cnt_ff == 2'd2);
   assign accept = start && !busy;

   always_comb begin
      cmd_in.op       = OP_SCHEDULE;
      cmd_in.time_val = req_due_time;
      cmd_in.id       = req_cancel_id;
      push            = 1'b0;
      case (req_kind)
         OP_SCHEDULE: begin
            push = accept;
         end
         OP_CANCEL: begin
            cmd_in.op = OP_CANCEL;
            push      = accept;
         end
         OP_TICK: begin
            cmd_in.op       = OP_TICK;
            cmd_in.time_val = req_current_time;
            push            = accept;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   assign head.vld = (cnt_ff != 2'd0);
   assign head.cmd = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= cmd_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

### src/ttq_back.sv
// Back end: task store, schedule, cancel scan and earliest-due tick scans.
// Depends on ttq_pkg and ttq_ram.
module ttq_back
   import ttq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  head_type head,
   output logic     pop,
   output rsp_type  rsp
);

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [AW:0]   SCAN_END = (AW+1)'(DEPTH);
   localparam logic [AW:0]   CNT_ONE  = (AW+1)'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CANCEL,
      ST_TICK
   } state_type;

   state_type        state_ff, state_in;
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic [31:0]      id_ctr_ff, id_ctr_in;
   cmd_type          cmd_ff, cmd_in;
   logic [AW:0]      scan_ff, scan_in;
   logic             pipe_vld_ff, pipe_vld_in;
   logic [AW-1:0]    pipe_idx_ff, pipe_idx_in;
   logic             found_ff, found_in;
   logic             best_vld_ff, best_vld_in;
   logic [AW-1:0]    best_idx_ff, best_idx_in;
   logic [47:0]      best_due_ff, best_due_in;
   logic [31:0]      best_id_ff, best_id_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic [RES_W-1:0] n_ff, n_in;
   rsp_type          rsp_ff, rsp_in;

   logic             free_any;
   logic [AW-1:0]    free_idx;
   logic             ram_we;
   entry_type        wr_entry;
   logic [$bits(entry_type)-1:0] rd_raw;
   entry_type        ent;
   logic             issue;
   logic             final_beat;
   logic             live;
   logic             cand;
   logic             better;
   logic             last_due;

   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = AW'(i);
         end
      end
   end

   assign wr_entry.id  = id_ctr_ff;
   assign wr_entry.due = head.cmd.time_val;

   ttq_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (free_idx),
      .wr_data (wr_entry),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (rd_raw)
   );

   assign ent        = entry_type'(rd_raw);
   assign issue      = (state_ff != ST_IDLE) && (scan_ff < SCAN_END);
   assign final_beat = pipe_vld_ff && (pipe_idx_ff == LAST_IDX);
   assign live       = pipe_vld_ff && valid_ff[pipe_idx_ff];
   assign cand       = live && (ent.due <= cmd_ff.time_val);
   assign better     = !best_vld_ff || (ent.due < best_due_ff) ||
                       ((ent.due == best_due_ff) && (ent.id < best_id_ff));

   always_comb begin
      state_in    = state_ff;
      valid_in    = valid_ff;
      id_ctr_in   = id_ctr_ff;
      cmd_in      = cmd_ff;
      scan_in     = scan_ff;
      pipe_vld_in = issue;
      pipe_idx_in = scan_ff[AW-1:0];
      found_in    = found_ff;
      best_vld_in = best_vld_ff;
      best_idx_in = best_idx_ff;
      best_due_in = best_due_ff;
      best_id_in  = best_id_ff;
      cnt_in      = cnt_ff;
      n_in        = n_ff;
      rsp_in      = '0;
      pop         = 1'b0;
      ram_we      = 1'b0;
      last_due    = 1'b0;

      if (issue) begin
         scan_in = scan_ff + CNT_ONE;
      end

      case (state_ff)
         ST_IDLE: begin
            if (head.vld) begin
               pop    = 1'b1;
               cmd_in = head.cmd;
               case (head.cmd.op)
                  OP_SCHEDULE: begin
                     rsp_in.strobe = 1'b1;
                     rsp_in.last   = 1'b1;
                     if (free_any) begin
                        ram_we             = 1'b1;
                        valid_in[free_idx] = 1'b1;
                        rsp_in.kind        = RK_ASSIGNED;
                        rsp_in.task_id     = id_ctr_ff;
                        id_ctr_in          = id_ctr_ff + 32'd1;
                     end else begin
                        rsp_in.kind = RK_FULL;
                     end
                  end
                  OP_CANCEL: begin
                     state_in = ST_CANCEL;
                     scan_in  = '0;
                     found_in = 1'b0;
                  end
                  OP_TICK: begin
                     state_in    = ST_TICK;
                     scan_in     = '0;
                     best_vld_in = 1'b0;
                     cnt_in      = '0;
                     n_in        = '0;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CANCEL: begin
            if (live && (ent.id == cmd_ff.id)) begin
               valid_in[pipe_idx_ff] = 1'b0;
               found_in              = 1'b1;
            end
            if (final_beat) begin
               rsp_in.strobe  = 1'b1;
               rsp_in.kind    = RK_CANCEL;
               rsp_in.task_id = cmd_ff.id;
               rsp_in.found   = found_in;
               rsp_in.last    = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_TICK: begin
            if (cand) begin
               cnt_in = cnt_ff + CNT_ONE;
               if (better) begin
                  best_vld_in = 1'b1;
                  best_idx_in = pipe_idx_ff;
                  best_due_in = ent.due;
                  best_id_in  = ent.id;
               end
            end
            if (final_beat) begin
               if (best_vld_in) begin
                  last_due                = (cnt_in == CNT_ONE) || (n_ff == RES_LAST);
                  valid_in[best_idx_in]   = 1'b0;
                  rsp_in.strobe           = 1'b1;
                  rsp_in.kind             = RK_DUE;
                  rsp_in.task_id          = best_id_in;
                  rsp_in.last             = last_due;
                  if (last_due) begin
                     state_in = ST_IDLE;
                  end else begin
                     scan_in     = '0;
                     best_vld_in = 1'b0;
                     cnt_in      = '0;
                     n_in        = n_ff + RES_W'(1);
                  end
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_in_hold: begin
         cmd_ff      <= cmd_in;
         pipe_idx_ff <= pipe_idx_in;
         best_idx_ff <= best_idx_in;
         best_due_ff <= best_due_in;
         best_id_ff  <= best_id_in;
         found_ff    <= found_in;
         cnt_ff      <= cnt_in;
         n_ff        <= n_in;
         scan_ff     <= scan_in;
         rsp_ff.kind    <= rsp_in.kind;
         rsp_ff.task_id <= rsp_in.task_id;
         rsp_ff.found   <= rsp_in.found;
         rsp_ff.last    <= rsp_in.last;
      end
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         id_ctr_ff     <= '0;
         pipe_vld_ff   <= 1'b0;
         best_vld_ff   <= 1'b0;
         rsp_ff.strobe <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         id_ctr_ff     <= id_ctr_in;
         pipe_vld_ff   <= pipe_vld_in;
         best_vld_ff   <= best_vld_in;
         rsp_ff.strobe <= rsp_in.strobe;
      end
   end

   assign rsp = rsp_ff;

endmodule

### src/timed_task_queue_with_cancel_top.sv
// Channel   Ports                                   Handshake
// request   req_kind req_due_time req_cancel_id     start, accepted when busy is low
//           req_current_time
// response  rsp_result_kind rsp_task_id             rsp_strobe, a one-cycle strobe per result
//           rsp_cancel_found rsp_last
//
// Schedule: the result is registered once the back end takes the command. Cancel: one
// store read per cycle while the store is scanned. Tick: one scan pass per fired task
// (at least one), since the store has a single read port.
// A two-entry command queue lets up to two transactions wait; busy rises when it fills.
// Reset is synchronous: store empty, id counter zero. Results cannot be stalled.
// Top level of the timed task queue; depends on ttq_pkg, ttq_front, ttq_back.
module timed_task_queue_with_cancel_top
   import ttq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [47:0] req_due_time,
   input  logic [31:0] req_cancel_id,
   input  logic [47:0] req_current_time,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_result_kind,
   output logic [31:0] rsp_task_id,
   output logic        rsp_cancel_found,
   output logic        rsp_last
);

   head_type head;
   logic     pop;
   rsp_type  rsp;

   ttq_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_due_time     (req_due_time),
      .req_cancel_id    (req_cancel_id),
      .req_current_time (req_current_time),
      .pop              (pop),
      .head             (head)
   );

   ttq_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp)
   );

   assign rsp_strobe       = rsp.strobe;
   assign rsp_result_kind  = rsp.kind;
   assign rsp_task_id      = rsp.task_id;
   assign rsp_cancel_found = rsp.found;
   assign rsp_last         = rsp.last;

endmodule

### src/ttq_checker.sv
// Port-level checker for the timed task queue, bound to the top level.
// Depends on ttq_pkg and timed_task_queue_with_cancel_top_macros.svh.
`include "timed_task_queue_with_cancel_top_macros.svh"

module ttq_checker
   import ttq_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_strobe,
   input logic [1:0]  rsp_result_kind,
   input logic [31:0] rsp_task_id,
   input logic        rsp_cancel_found,
   input logic        rsp_last
);

   `TTQ_ASSERT_SAME(a_single_last, rsp_strobe && (rsp_result_kind != RK_DUE), rsp_last, "non-tick transaction not marked last")
   `TTQ_ASSERT_SAME(a_found_only_cancel, rsp_strobe && (rsp_result_kind != RK_CANCEL), !rsp_cancel_found, "cancel_found set outside a cancel answer")
   `TTQ_ASSERT_SAME(a_full_zero_id, rsp_strobe && (rsp_result_kind == RK_FULL), rsp_task_id == 32'd0, "store full with nonzero id")
   `TTQ_ASSERT_NEXT(a_id_step, rsp_strobe && (rsp_result_kind == RK_ASSIGNED), !(rsp_strobe && (rsp_result_kind == RK_ASSIGNED)) || (rsp_task_id == $past(rsp_task_id) + 32'd1), "back-to-back assigned ids not consecutive")

endmodule

bind timed_task_queue_with_cancel_top ttq_checker u_ttq_checker (.*);

### tb/timed_task_queue_checker.sv
// Checker for the timed task queue: mirrors the task store, predicts each result
// and compares it with what the block emits. Depends on ttq_pkg.
module timed_task_queue_checker
   import ttq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [47:0] req_due_time,
   input  logic [31:0] req_cancel_id,
   input  logic [47:0] req_current_time,
   input  logic        rsp_strobe,
   input  logic [1:0]  rsp_result_kind,
   input  logic [31:0] rsp_task_id,
   input  logic        rsp_cancel_found,
   input  logic        rsp_last,
   output int          mismatches,
   output int          outstanding
);

   typedef struct {
      logic [1:0]  kind;
      logic [31:0] id;
      logic        found;
      logic        last;
   } reply_type;

   logic        slot_live [DEPTH];
   logic [31:0] slot_id   [DEPTH];
   logic [47:0] slot_due  [DEPTH];
   logic [31:0] id_next;

   reply_type   expected_replies [$];
   reply_type   want;
   int          err_count = 0;

   task automatic predict_replies(input logic [1:0] kind, input logic [47:0] due,
                                  input logic [31:0] cid, input logic [47:0] now);
      int        free_slot;
      int        best;
      int        fired;
      logic      hit;
      reply_type r;
      case (kind)
         OP_SCHEDULE: begin
            free_slot = -1;
            for (int i = 0; i < DEPTH; i++)
               if (!slot_live[i] && free_slot < 0) free_slot = i;
            if (free_slot >= 0) begin
               slot_live[free_slot] = 1'b1;
               slot_id[free_slot]   = id_next;
               slot_due[free_slot]  = due;
               r = '{RK_ASSIGNED, id_next, 1'b0, 1'b1};
               id_next = id_next + 32'd1;
            end else begin
               r = '{RK_FULL, 32'd0, 1'b0, 1'b1};
            end
            expected_replies.push_back(r);
         end
         OP_CANCEL: begin
            hit = 1'b0;
            for (int i = 0; i < DEPTH; i++)
               if (slot_live[i] && slot_id[i] == cid) begin
                  slot_live[i] = 1'b0;
                  hit = 1'b1;
               end
            r = '{RK_CANCEL, cid, hit, 1'b1};
            expected_replies.push_back(r);
         end
         OP_TICK: begin
            fired = 0;
            while (fired < MAX_RESULTS) begin
               best = -1;
               for (int i = 0; i < DEPTH; i++)
                  if (slot_live[i] && slot_due[i] <= now)
                     if (best < 0 || slot_due[i] < slot_due[best] ||
                         (slot_due[i] == slot_due[best] && slot_id[i] < slot_id[best]))
                        best = i;
               if (best < 0) break;
               slot_live[best] = 1'b0;
               r = '{RK_DUE, slot_id[best], 1'b0, 1'b0};
               expected_replies.push_back(r);
               fired++;
            end
            if (fired > 0) expected_replies[expected_replies.size() - 1].last = 1'b1;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) slot_live[i] = 1'b0;
         id_next = 32'd0;
         expected_replies.delete();
      end else begin
         if (start && busy === 1'b0)
            predict_replies(req_kind, req_due_time, req_cancel_id, req_current_time);
         if (rsp_strobe === 1'b1) begin
            if (expected_replies.size() == 0) begin
               $error("unexpected result: kind %0d task_id %0d", rsp_result_kind, rsp_task_id);
               err_count++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_result_kind !== want.kind) begin
                  $error("result_kind: expected %0d, got %0d", want.kind, rsp_result_kind);
                  err_count++;
               end
               if (rsp_task_id !== want.id) begin
                  $error("task_id: expected %0d, got %0d", want.id, rsp_task_id);
                  err_count++;
               end
               if (rsp_cancel_found !== want.found) begin
                  $error("cancel_found: expected %0d, got %0d", want.found, rsp_cancel_found);
                  err_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  err_count++;
               end
            end
         end
      end
      mismatches  <= err_count;
      outstanding <= expected_replies.size();
   end

endmodule

### tb/timed_task_queue_with_cancel_top_test.sv
// Testbench top for the timed task queue: drives directed and random transactions,
// runs a watchdog and reports the verdict. Depends on ttq_pkg, the top level and the checker module.
module timed_task_queue_with_cancel_top_test;
   import ttq_pkg::*;

   localparam int          DEPTH        = 16;
   localparam int          QUIET_LIMIT  = 2000;
   localparam int          DRAIN_CYCLES = 400;
   localparam int          PHASE_ITEMS  = 30;
   localparam logic [1:0]  KIND_UNUSED  = 2'd3;
   localparam logic [47:0] TIME_MAX     = 48'hFFFF_FFFF_FFFF;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        start            = 1'b0;
   logic [1:0]  req_kind         = '0;
   logic [47:0] req_due_time     = '0;
   logic [31:0] req_cancel_id    = '0;
   logic [47:0] req_current_time = '0;
   logic        busy;
   logic        rsp_strobe;
   logic [1:0]  rsp_result_kind;
   logic [31:0] rsp_task_id;
   logic        rsp_cancel_found;
   logic        rsp_last;
   int          mismatches;
   int          outstanding;

   int          idle_pct      = 0;
   int          items_sent    = 0;
   int          results_seen  = 0;
   int          quiet_cycles  = 0;
   logic [31:0] ids_issued    = '0;
   logic [47:0] time_now;

   always #1 clock = ~clock;

   timed_task_queue_with_cancel_top #(.DEPTH(DEPTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_due_time     (req_due_time),
      .req_cancel_id    (req_cancel_id),
      .req_current_time (req_current_time),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_task_id      (rsp_task_id),
      .rsp_cancel_found (rsp_cancel_found),
      .rsp_last         (rsp_last)
   );

   timed_task_queue_checker #(.DEPTH(DEPTH)) reply_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_due_time     (req_due_time),
      .req_cancel_id    (req_cancel_id),
      .req_current_time (req_current_time),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_task_id      (rsp_task_id),
      .rsp_cancel_found (rsp_cancel_found),
      .rsp_last         (rsp_last),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_strobe === 1'b1) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (rsp_strobe === 1'b1) results_seen <= results_seen + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [47:0] rand48();
      logic [63:0] full;
      full = {$urandom(), $urandom()};
      return full[47:0];
   endfunction

   task automatic send_item(input logic [1:0] kind, input logic [47:0] due,
                            input logic [31:0] cid, input logic [47:0] now);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_kind         <= kind;
      req_due_time     <= due;
      req_cancel_id    <= cid;
      req_current_time <= now;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      items_sent++;
      if (kind == OP_SCHEDULE) ids_issued = ids_issued + 32'd1;
   endtask

   initial begin
      int          sel;
      int          count;
      int          pick;
      logic [47:0] due;
      logic [31:0] cid;
      logic [47:0] now;

      time_now = rand48();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, unknown cancel, empty tick, unused kind
      idle_pct = 10;
      send_item(OP_SCHEDULE, 48'd0, $urandom(), rand48());
      send_item(OP_SCHEDULE, TIME_MAX, $urandom(), rand48());
      send_item(OP_CANCEL, rand48(), 32'hFFFF_FFFF, rand48());
      send_item(OP_TICK, rand48(), $urandom(), 48'd0);
      send_item(OP_TICK, rand48(), $urandom(), 48'd0);
      send_item(KIND_UNUSED, rand48(), $urandom(), rand48());
      // fill the store, ties on due time among the first few
      for (int k = 0; k < 15; k++)
         send_item(OP_SCHEDULE, (k < 6) ? 48'd5 : 48'(k * 3), $urandom(), rand48());
      send_item(OP_SCHEDULE, rand48(), $urandom(), rand48());
      send_item(OP_TICK, rand48(), $urandom(), TIME_MAX);
      send_item(OP_SCHEDULE, TIME_MAX, $urandom(), rand48());
      send_item(OP_CANCEL, rand48(), 32'd17, rand48());

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 10 : (phase == 1) ? 51 : 0;
         count = 0;
         while (count < PHASE_ITEMS) begin
            sel = $urandom_range(99);
            if (sel < 5) begin
               send_item(KIND_UNUSED, rand48(), $urandom(), rand48());
            end else if (sel < 50) begin
               due = ($urandom_range(9) == 0) ? rand48() : time_now + 48'($urandom_range(60));
               send_item(OP_SCHEDULE, due, $urandom(), rand48());
               count++;
            end else if (sel < 70) begin
               cid = ($urandom_range(4) == 0) ? $urandom()
                                              : ids_issued - 32'($urandom_range(8));
               send_item(OP_CANCEL, rand48(), cid, rand48());
               count++;
            end else begin
               time_now = time_now + 48'($urandom_range(40));
               pick = $urandom_range(19);
               now = (pick == 0) ? TIME_MAX : (pick == 1) ? rand48() : time_now;
               send_item(OP_TICK, rand48(), $urandom(), now);
               count++;
            end
         end
      end
      start <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d transactions (schedule, cancel, tick, unused kind)", items_sent);
      $display("and %0d results, with full store, ties and sender gaps", results_seen);
      if (mismatches == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### timed_task_queue_with_cancel_top.f
+incdir+src
src/ttq_pkg.sv
src/ttq_ram.sv
src/ttq_front.sv
src/ttq_back.sv
src/timed_task_queue_with_cancel_top.sv
src/ttq_checker.sv
tb/timed_task_queue_checker.sv
tb/timed_task_queue_with_cancel_top_test.sv
